FILE: hdl/hsvrgb_pkg.sv
// ----------------------------------------------------------------------------
// hsvrgb_pkg
// Shared types, constants and helper functions of the HSV to RGB converter.
// ----------------------------------------------------------------------------
package hsvrgb_pkg;

    localparam int unsigned PIX_W   = 8;   // one colour component
    localparam int unsigned PROD_W  = 16;  // v*s and v*(255-s)
    localparam int unsigned CH_W    = 24;  // channel in units of 1/255^3
    localparam int unsigned NUM_W   = 35;  // scaled numerator before division
    localparam int unsigned NUM_CH  = 3;
    localparam int unsigned DIV_STG = 4;   // radix-4 digits of the quotient

    // floor((2558*x + 16581375) / 165813750) == floor((1279*x + 8290687) / 82906875)
    localparam logic [10:0]      GAIN    = 11'd1279;
    localparam logic [NUM_W-1:0] OFFSET  = NUM_W'(64'd8290687);
    localparam logic [NUM_W-1:0] DIVISOR = NUM_W'(64'd82906875);

    typedef enum logic [2:0] {
        SEC_RY = 3'd0,  // red to yellow
        SEC_YG = 3'd1,  // yellow to green
        SEC_GC = 3'd2,  // green to cyan
        SEC_CB = 3'd3,  // cyan to blue
        SEC_BM = 3'd4,  // blue to magenta
        SEC_MR = 3'd5   // magenta to red, full hue included
    } t_sector;

    typedef struct packed {
        t_sector          sec;
        logic [PIX_W-1:0] frac;
    } t_split;

    typedef struct packed {
        t_sector         sec;
        logic [CH_W-1:0] c;
        logic [CH_W-1:0] p;
        logic [CH_W-1:0] q;
        logic [CH_W-1:0] m;
    } t_front;

    typedef logic [NUM_CH-1:0][NUM_W-1:0] t_num3;
    typedef logic [NUM_CH-1:0][PIX_W-1:0] t_rgb;

    typedef struct packed {
        logic [1:0]       digit;
        logic [NUM_W-1:0] rem;
    } t_div_step;

    // Split 6*hue into sector and the remainder modulo 255; full hue lands
    // in the last sector with remainder 255.
    function automatic t_split hsv_split(input logic [PIX_W-1:0] hue);
        logic [10:0] h6;
        t_split      res;
        h6 = 11'({hue, 2'b00}) + 11'({hue, 1'b0});
        if (h6 >= 11'd1275) begin
            res.sec  = SEC_MR;
            res.frac = 8'(h6 - 11'd1275);
        end else if (h6 >= 11'd1020) begin
            res.sec  = SEC_BM;
            res.frac = 8'(h6 - 11'd1020);
        end else if (h6 >= 11'd765) begin
            res.sec  = SEC_CB;
            res.frac = 8'(h6 - 11'd765);
        end else if (h6 >= 11'd510) begin
            res.sec  = SEC_GC;
            res.frac = 8'(h6 - 11'd510);
        end else if (h6 >= 11'd255) begin
            res.sec  = SEC_YG;
            res.frac = 8'(h6 - 11'd255);
        end else begin
            res.sec  = SEC_RY;
            res.frac = 8'(h6);
        end
        return res;
    endfunction

    // One radix-4 restoring digit against the divisor shifted by sh bits.
    function automatic t_div_step div_step(input logic [NUM_W-1:0] rem,
                                           input int unsigned      sh);
        logic [NUM_W-1:0] d1;
        logic [NUM_W-1:0] d2;
        logic [NUM_W-1:0] d3;
        t_div_step        res;
        d1 = DIVISOR << sh;
        d2 = d1 << 1;
        d3 = d1 + d2;
        if (rem >= d3) begin
            res.digit = 2'd3;
            res.rem   = rem - d3;
        end else if (rem >= d2) begin
            res.digit = 2'd2;
            res.rem   = rem - d2;
        end else if (rem >= d1) begin
            res.digit = 2'd1;
            res.rem   = rem - d1;
        end else begin
            res.digit = 2'd0;
            res.rem   = rem;
        end
        return res;
    endfunction

endpackage

FILE: hdl/hsvrgb_front.sv
// ----------------------------------------------------------------------------
// hsvrgb_front
// Two stages: hue split and v*s products, then chroma, P, Q and offset terms.
// ----------------------------------------------------------------------------
module hsvrgb_front
    import hsvrgb_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_vld,
    output logic             o_rdy,
    input  logic [PIX_W-1:0] i_hue,
    input  logic [PIX_W-1:0] i_sat,
    input  logic [PIX_W-1:0] i_val,
    output logic             o_vld,
    input  logic             i_rdy,
    output t_front           o_data
);

    logic              r_s1_vld;
    t_sector           r_s1_sec;
    logic [PIX_W-1:0]  r_s1_frac;
    logic [PROD_W-1:0] r_s1_vs;
    logic [PROD_W-1:0] r_s1_w;
    logic              r_s2_vld;
    t_front            r_s2_data;

    logic   en1;
    logic   en2;
    t_split split;
    t_front n_s2_data;

    assign en2   = !r_s2_vld || i_rdy;
    assign en1   = !r_s1_vld || en2;
    assign o_rdy = en1;
    assign split = hsv_split(i_hue);

    always_comb begin
        n_s2_data.sec = r_s1_sec;
        n_s2_data.c   = CH_W'({r_s1_vs, 8'h00}) - CH_W'(r_s1_vs);
        n_s2_data.p   = CH_W'(r_s1_vs) * CH_W'(r_s1_frac);
        n_s2_data.q   = CH_W'(r_s1_vs) * CH_W'(PIX_W'(~r_s1_frac));
        n_s2_data.m   = CH_W'({r_s1_w, 8'h00}) - CH_W'(r_s1_w);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else begin
            if (en1) r_s1_vld <= i_vld;
            if (en2) r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_s1_sec  <= split.sec;
            r_s1_frac <= split.frac;
            r_s1_vs   <= PROD_W'(i_val) * PROD_W'(i_sat);
            r_s1_w    <= PROD_W'(i_val) * PROD_W'(PIX_W'(~i_sat));
        end
        if (en2) begin
            r_s2_data <= n_s2_data;
        end
    end

    assign o_vld  = r_s2_vld;
    assign o_data = r_s2_data;

endmodule

FILE: hdl/hsvrgb_mix.sv
// ----------------------------------------------------------------------------
// hsvrgb_mix
// Two stages: route terms to channels by sector and add the offset, then
// scale each channel into the numerator of the final division.
// ----------------------------------------------------------------------------
module hsvrgb_mix
    import hsvrgb_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_vld,
    output logic   o_rdy,
    input  t_front i_data,
    output logic   o_vld,
    input  logic   i_rdy,
    output t_num3  o_num
);

    logic                       r_s3_vld;
    logic [NUM_CH-1:0][CH_W-1:0] r_s3_x;
    logic                       r_s4_vld;
    t_num3                      r_s4_num;

    logic                        en3;
    logic                        en4;
    logic [NUM_CH-1:0][CH_W-1:0] sel;
    t_num3                       n_s4_num;

    assign en4   = !r_s4_vld || i_rdy;
    assign en3   = !r_s3_vld || en4;
    assign o_rdy = en3;

    // channel order: red, green, blue
    always_comb begin
        case (i_data.sec)
            SEC_RY:  sel = {CH_W'(0),  i_data.p, i_data.c};
            SEC_YG:  sel = {CH_W'(0),  i_data.c, i_data.q};
            SEC_GC:  sel = {i_data.p,  i_data.c, CH_W'(0)};
            SEC_CB:  sel = {i_data.c,  i_data.q, CH_W'(0)};
            SEC_BM:  sel = {i_data.c,  CH_W'(0), i_data.p};
            default: sel = {i_data.q,  CH_W'(0), i_data.c};
        endcase
    end

    always_comb begin
        for (int ch = 0; ch < NUM_CH; ch++) begin
            n_s4_num[ch] = NUM_W'(r_s3_x[ch]) * NUM_W'(GAIN) + OFFSET;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_vld <= 1'b0;
            r_s4_vld <= 1'b0;
        end else begin
            if (en3) r_s3_vld <= i_vld;
            if (en4) r_s4_vld <= r_s3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            for (int ch = 0; ch < NUM_CH; ch++) begin
                r_s3_x[ch] <= sel[ch] + i_data.m;
            end
        end
        if (en4) begin
            r_s4_num <= n_s4_num;
        end
    end

    assign o_vld = r_s4_vld;
    assign o_num = r_s4_num;

endmodule

FILE: hdl/hsvrgb_div.sv
// ----------------------------------------------------------------------------
// hsvrgb_div
// Radix-4 restoring division by a constant, one quotient digit per stage.
// ----------------------------------------------------------------------------
module hsvrgb_div
    import hsvrgb_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_vld,
    output logic  o_rdy,
    input  t_num3 i_num,
    output logic  o_vld,
    input  logic  i_rdy,
    output t_rgb  o_rgb
);

    logic [DIV_STG-1:0] r_vld;
    t_num3              r_rem [DIV_STG-1];
    t_rgb               r_quo [DIV_STG];
    logic [DIV_STG-1:0] en;

    always_comb begin
        en[DIV_STG-1] = !r_vld[DIV_STG-1] || i_rdy;
        for (int k = DIV_STG - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign o_rdy = en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) r_vld[0] <= i_vld;
            for (int k = 1; k < DIV_STG; k++) begin
                if (en[k]) r_vld[k] <= r_vld[k-1];
            end
        end
    end

    for (genvar k = 0; k < DIV_STG; k++) begin : g_stg
        t_num3     rem_in;
        t_rgb      quo_in;
        t_div_step step [NUM_CH];

        if (k == 0) begin : g_first
            assign rem_in = i_num;
            assign quo_in = '0;
        end else begin : g_next
            assign rem_in = r_rem[k-1];
            assign quo_in = r_quo[k-1];
        end

        always_comb begin
            for (int ch = 0; ch < NUM_CH; ch++) begin
                step[ch] = div_step(rem_in[ch], 2 * (DIV_STG - 1 - k));
            end
        end

        always_ff @(posedge i_clk) begin
            if (en[k]) begin
                for (int ch = 0; ch < NUM_CH; ch++) begin
                    r_quo[k][ch] <= {quo_in[ch][PIX_W-3:0], step[ch].digit};
                end
            end
        end

        if (k < DIV_STG - 1) begin : g_rem
            always_ff @(posedge i_clk) begin
                if (en[k]) begin
                    for (int ch = 0; ch < NUM_CH; ch++) begin
                        r_rem[k][ch] <= step[ch].rem;
                    end
                end
            end
        end
    end

    assign o_vld = r_vld[DIV_STG-1];
    assign o_rgb = r_quo[DIV_STG-1];

endmodule

FILE: hdl/hsv_to_rgb_convert_core.sv
// ----------------------------------------------------------------------------
// hsv_to_rgb_convert_core
// HSV to RGB colour converter, eight-stage pipeline, one pixel per cycle while the output is ready.
// ----------------------------------------------------------------------------
// Converts one pixel per clock cycle, sustained while the output accepts
// results, each accepted input word giving one output word. Hue, saturation and
// value are 8-bit fractions of 255; the result is exact: every channel is
// worked in integer units of 1/255^3 and rounded as floor(0.1 + 255.8*x).
// The depth is set by the final constant division, which resolves two
// quotient bits per stage over four stages; the first four stages split the
// hue, form the chroma products and scale each channel. Every stage holds
// its own valid bit and each stage's ready looks only at the stage after it,
// so bubbles close up and a new word is taken while a finished result waits
// on the output, as long as a bubble remains. There are no configuration
// registers and no state between pixels.
// ----------------------------------------------------------------------------
module hsv_to_rgb_convert_core
    import hsvrgb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,  // [7:0] hue, [15:8] saturation, [23:16] brightness
    // output stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata   // [7:0] red, [15:8] green, [23:16] blue
);

    logic   front_vld;
    logic   front_rdy;
    t_front front_data;
    logic   mix_vld;
    logic   mix_rdy;
    t_num3  mix_num;
    t_rgb   rgb;

    // Stages one and two: hue sector and fraction, v*s, then C, P, Q and M.
    hsvrgb_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (i_s_axis_tvalid),
        .o_rdy   (o_s_axis_tready),
        .i_hue   (i_s_axis_tdata[7:0]),
        .i_sat   (i_s_axis_tdata[15:8]),
        .i_val   (i_s_axis_tdata[23:16]),
        .o_vld   (front_vld),
        .i_rdy   (front_rdy),
        .o_data  (front_data)
    );

    // Stages three and four: route terms by sector, add M, scale numerator.
    hsvrgb_mix u_mix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (front_vld),
        .o_rdy   (front_rdy),
        .i_data  (front_data),
        .o_vld   (mix_vld),
        .i_rdy   (mix_rdy),
        .o_num   (mix_num)
    );

    // Stages five to eight: divide each channel down to eight bits.
    hsvrgb_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (mix_vld),
        .o_rdy   (mix_rdy),
        .i_num   (mix_num),
        .o_vld   (o_m_axis_tvalid),
        .i_rdy   (i_m_axis_tready),
        .o_rgb   (rgb)
    );

    // Pack the output word, red in the lowest byte.
    assign o_m_axis_tdata = {rgb[2], rgb[1], rgb[0]};

endmodule
